// ----- design/rdx51_pkg.sv -----
// shared constants and types for the radix-2^51 reduction pipeline
package rdx51_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned LIMB_W = 51;
	localparam int unsigned TOP_W = 52;
	localparam int unsigned CARRY_W = WORD_W - LIMB_W;
	localparam int unsigned WRAP_W = CARRY_W + 5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [TOP_W-1:0] top_limb_t;
	typedef logic [CARRY_W-1:0] carry_t;

	localparam limb_t MASK51 = 51'h7_ffff_ffff_ffff;
	localparam top_limb_t P_LOW_LIMB = 52'h7_ffff_ffff_ffed;

	// times 19 within the word, as shifts and adds
	function automatic word_t mul19_word(input word_t x);
		mul19_word = (x << 4) + (x << 1) + x;
	endfunction

	// carry times 19, widened for the wrap into the least significant limb
	function automatic logic [WRAP_W-1:0] mul19_carry(input carry_t c);
		logic [WRAP_W-1:0] cx;
		cx = {5'b0, c};
		mul19_carry = (cx << 4) + (cx << 1) + cx;
	endfunction

endpackage

// ----- design/radix51_mod_p25519_reduce.sv -----
// Throughput: one transaction per cycle; a stalled output freezes every stage at once.
// Stages: column split, four carry steps limb 3 to limb 0, wrap times 19, canonical fold.
// Reset clears all stage valid bits and sets canonical_enable to 1.
// The canonical_enable register is sampled in the fold stage.
module radix51_mod_p25519_reduce (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic                 cfg_wdata,
	input  logic                 col_valid,
	output logic                 col_stall,
	input  rdx51_pkg::word_t     col0_hi,
	input  rdx51_pkg::word_t     col0_lo,
	input  rdx51_pkg::word_t     col1_hi,
	input  rdx51_pkg::word_t     col1_lo,
	input  rdx51_pkg::word_t     col2_hi,
	input  rdx51_pkg::word_t     col2_lo,
	input  rdx51_pkg::word_t     col3_hi,
	input  rdx51_pkg::word_t     col3_lo,
	input  rdx51_pkg::word_t     col4_hi,
	input  rdx51_pkg::word_t     col4_lo,
	output logic                 limb_valid,
	input  logic                 limb_stall,
	output rdx51_pkg::limb_t     limb_0,
	output rdx51_pkg::limb_t     limb_1,
	output rdx51_pkg::limb_t     limb_2,
	output rdx51_pkg::limb_t     limb_3,
	output rdx51_pkg::top_limb_t limb_4
);

	localparam int unsigned LW = rdx51_pkg::LIMB_W;
	localparam int unsigned WW = rdx51_pkg::WORD_W;

	logic canonical_enable_q;
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// column split results
	rdx51_pkg::word_t up0, up1, up2, up3, up4;
	rdx51_pkg::word_t z0_c, z1_c, z2_c, z3_c, z4_c;
	rdx51_pkg::word_t z0_s1, z1_s1, z2_s1, z3_s1, z4_s1;

	rdx51_pkg::word_t  z0_s2, z1_s2, z2_s2;
	rdx51_pkg::limb_t  l3_s2, l4_s2;
	rdx51_pkg::carry_t c_s2;

	rdx51_pkg::word_t  z0_s3, z1_s3;
	rdx51_pkg::limb_t  l2_s3, l3_s3, l4_s3;
	rdx51_pkg::carry_t c_s3;

	rdx51_pkg::word_t  z0_s4;
	rdx51_pkg::limb_t  l1_s4, l2_s4, l3_s4, l4_s4;
	rdx51_pkg::carry_t c_s4;

	rdx51_pkg::limb_t  l0_s5, l1_s5, l2_s5, l3_s5, l4_s5;
	rdx51_pkg::carry_t c_s5;

	rdx51_pkg::limb_t     l0_s6, l1_s6, l2_s6, l3_s6;
	rdx51_pkg::top_limb_t l4_s6;

	rdx51_pkg::limb_t     l0_s7, l1_s7, l2_s7, l3_s7;
	rdx51_pkg::top_limb_t l4_s7;

	rdx51_pkg::limb_t  l3_c, l2_c, l1_c, l0_c;
	rdx51_pkg::carry_t c3_c, c2_c, c1_c, c0_c;

	rdx51_pkg::top_limb_t l4_wrap_c;
	logic                 fold_c;

	// whole pipeline moves unless a finished transaction is held at the output
	assign adv       = !(limb_valid && limb_stall);
	assign col_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canonical_enable_q <= 1'b1;
		end else if (cfg_wen) begin
			canonical_enable_q <= cfg_wdata;
		end
	end

	// upper part of a column: high word shifted by 13 within 64 bits
	assign up0 = {col0_hi[LW-1:0], col0_lo[WW-1:LW]};
	assign up1 = {col1_hi[LW-1:0], col1_lo[WW-1:LW]};
	assign up2 = {col2_hi[LW-1:0], col2_lo[WW-1:LW]};
	assign up3 = {col3_hi[LW-1:0], col3_lo[WW-1:LW]};
	assign up4 = {col4_hi[LW-1:0], col4_lo[WW-1:LW]};

	assign z0_c = {{rdx51_pkg::CARRY_W{1'b0}}, col0_lo[LW-1:0]} + up1;
	assign z1_c = {{rdx51_pkg::CARRY_W{1'b0}}, col1_lo[LW-1:0]} + up2;
	assign z2_c = {{rdx51_pkg::CARRY_W{1'b0}}, col2_lo[LW-1:0]} + up3;
	assign z3_c = {{rdx51_pkg::CARRY_W{1'b0}}, col3_lo[LW-1:0]} + up4;
	assign z4_c = {{rdx51_pkg::CARRY_W{1'b0}}, col4_lo[LW-1:0]} + rdx51_pkg::mul19_word(up0);

	rdx51_carry u_carry3 (.z(z3_s1), .cin(z4_s1[WW-1:LW]), .limb(l3_c), .cout(c3_c));
	rdx51_carry u_carry2 (.z(z2_s2), .cin(c_s2),           .limb(l2_c), .cout(c2_c));
	rdx51_carry u_carry1 (.z(z1_s3), .cin(c_s3),           .limb(l1_c), .cout(c1_c));
	rdx51_carry u_carry0 (.z(z0_s4), .cin(c_s4),           .limb(l0_c), .cout(c0_c));

	assign l4_wrap_c = {1'b0, l4_s5} + {{(rdx51_pkg::TOP_W - rdx51_pkg::WRAP_W){1'b0}},
		rdx51_pkg::mul19_carry(c_s5)};

	// value at or above the prime: limbs 0 to 3 all ones and limb 4 at or past the low limb of p
	assign fold_c = canonical_enable_q &&
		(l0_s6 == rdx51_pkg::MASK51) && (l1_s6 == rdx51_pkg::MASK51) &&
		(l2_s6 == rdx51_pkg::MASK51) && (l3_s6 == rdx51_pkg::MASK51) &&
		(l4_s6 >= rdx51_pkg::P_LOW_LIMB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= col_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z0_s1 <= z0_c;
			z1_s1 <= z1_c;
			z2_s1 <= z2_c;
			z3_s1 <= z3_c;
			z4_s1 <= z4_c;

			z0_s2 <= z0_s1;
			z1_s2 <= z1_s1;
			z2_s2 <= z2_s1;
			l3_s2 <= l3_c;
			l4_s2 <= z4_s1[LW-1:0];
			c_s2  <= c3_c;

			z0_s3 <= z0_s2;
			z1_s3 <= z1_s2;
			l2_s3 <= l2_c;
			l3_s3 <= l3_s2;
			l4_s3 <= l4_s2;
			c_s3  <= c2_c;

			z0_s4 <= z0_s3;
			l1_s4 <= l1_c;
			l2_s4 <= l2_s3;
			l3_s4 <= l3_s3;
			l4_s4 <= l4_s3;
			c_s4  <= c1_c;

			l0_s5 <= l0_c;
			l1_s5 <= l1_s4;
			l2_s5 <= l2_s4;
			l3_s5 <= l3_s4;
			l4_s5 <= l4_s4;
			c_s5  <= c0_c;

			l0_s6 <= l0_s5;
			l1_s6 <= l1_s5;
			l2_s6 <= l2_s5;
			l3_s6 <= l3_s5;
			l4_s6 <= l4_wrap_c;

			if (fold_c) begin
				l0_s7 <= '0;
				l1_s7 <= '0;
				l2_s7 <= '0;
				l3_s7 <= '0;
				l4_s7 <= l4_s6 - rdx51_pkg::P_LOW_LIMB;
			end else begin
				l0_s7 <= l0_s6;
				l1_s7 <= l1_s6;
				l2_s7 <= l2_s6;
				l3_s7 <= l3_s6;
				l4_s7 <= l4_s6;
			end
		end
	end

	assign limb_valid = v_s7;
	assign limb_0     = l0_s7;
	assign limb_1     = l1_s7;
	assign limb_2     = l2_s7;
	assign limb_3     = l3_s7;
	assign limb_4     = l4_s7;

`ifndef SYNTH
	// a held output must hold back the input side
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(limb_valid && limb_stall) |-> col_stall)
		else $error("input accepted while output transaction held");

	// a new output transaction comes only from the fold stage moving forward
	a_valid_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(limb_valid) |-> $past(v_s6))
		else $error("output valid without a transaction in the fold stage");

	// with folding on, no value at or above the prime leaves the block
	a_canonical_out: assert property (@(posedge clk) disable iff (!arst_n)
		(limb_valid && canonical_enable_q) |->
		!((limb_0 == rdx51_pkg::MASK51) && (limb_1 == rdx51_pkg::MASK51) &&
		  (limb_2 == rdx51_pkg::MASK51) && (limb_3 == rdx51_pkg::MASK51) &&
		  (limb_4 >= rdx51_pkg::P_LOW_LIMB)))
		else $error("non-canonical result with folding enabled");
`endif

endmodule

// ----- design/rdx51_carry.sv -----
// one carry step: adds an incoming carry to a word and splits it at bit 51
module rdx51_carry (
	input  rdx51_pkg::word_t  z,
	input  rdx51_pkg::carry_t cin,
	output rdx51_pkg::limb_t  limb,
	output rdx51_pkg::carry_t cout
);

	rdx51_pkg::word_t sum;

	assign sum  = z + {{rdx51_pkg::LIMB_W{1'b0}}, cin};
	assign limb = sum[rdx51_pkg::LIMB_W-1:0];
	assign cout = sum[rdx51_pkg::WORD_W-1:rdx51_pkg::LIMB_W];

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the radix-2^51 reduction modulo 2^255-19
module testbench;

	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 235;
	localparam int unsigned RANDOM_PHASES = 4;
	localparam rdx51_pkg::word_t FOLD_MUL = 64'd19;
	localparam rdx51_pkg::word_t ONES = '1;
	localparam rdx51_pkg::word_t M51 = 64'h0007_ffff_ffff_ffff;
	localparam rdx51_pkg::word_t P4 = 64'h0007_ffff_ffff_ffed;
	localparam rdx51_pkg::word_t HI13 = 64'hfff8_0000_0000_0000;
	localparam rdx51_pkg::word_t BIT51 = 64'h0008_0000_0000_0000;
	localparam rdx51_pkg::word_t PAT_A = 64'ha5a5_a5a5_a5a5_a5a5;
	localparam rdx51_pkg::word_t PAT_B = 64'h5a5a_5a5a_5a5a_5a5a;

	typedef struct {
		rdx51_pkg::limb_t     l0;
		rdx51_pkg::limb_t     l1;
		rdx51_pkg::limb_t     l2;
		rdx51_pkg::limb_t     l3;
		rdx51_pkg::top_limb_t l4;
	} limbs_t;

	typedef struct {
		rdx51_pkg::word_t col[10];
		bit               canon;
		bit               typed;
		limbs_t           want;
	} vector_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic                 cfg_wdata;
	logic                 col_valid;
	logic                 col_stall;
	rdx51_pkg::word_t     col0_hi, col0_lo, col1_hi, col1_lo, col2_hi;
	rdx51_pkg::word_t     col2_lo, col3_hi, col3_lo, col4_hi, col4_lo;
	logic                 limb_valid;
	logic                 limb_stall;
	rdx51_pkg::limb_t     limb_0, limb_1, limb_2, limb_3;
	rdx51_pkg::top_limb_t limb_4;

	bit          canon_model;
	limbs_t      pending_limbs[$];
	vector_t     directed[$];
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned fold_hits;
	int unsigned idle_cycles;
	int unsigned reg_writes;
	int unsigned directed_sent;
	int unsigned random_sent;
	int unsigned send_quiet;
	int unsigned recv_quiet;

	radix51_mod_p25519_reduce dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.col_valid  (col_valid),
		.col_stall  (col_stall),
		.col0_hi    (col0_hi),
		.col0_lo    (col0_lo),
		.col1_hi    (col1_hi),
		.col1_lo    (col1_lo),
		.col2_hi    (col2_hi),
		.col2_lo    (col2_lo),
		.col3_hi    (col3_hi),
		.col3_lo    (col3_lo),
		.col4_hi    (col4_hi),
		.col4_lo    (col4_lo),
		.limb_valid (limb_valid),
		.limb_stall (limb_stall),
		.limb_0     (limb_0),
		.limb_1     (limb_1),
		.limb_2     (limb_2),
		.limb_3     (limb_3),
		.limb_4     (limb_4)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// column split, one carry pass, wrap times 19, optional fold below the prime
	function automatic limbs_t reduce_mod_p(input rdx51_pkg::word_t c[10], input bit canon);
		rdx51_pkg::word_t up[5];
		rdx51_pkg::word_t lw[5];
		rdx51_pkg::word_t z[5];
		rdx51_pkg::word_t cy;
		limbs_t           r;
		int               k;
		for (k = 0; k < 5; k++) begin
			up[k] = (c[2*k] << 13) | (c[2*k+1] >> 51);
			lw[k] = c[2*k+1] & M51;
		end
		for (k = 0; k < 4; k++)
			z[k] = lw[k] + up[k+1];
		z[4] = lw[4] + up[0] * FOLD_MUL;
		cy = z[4] >> 51;
		z[4] = z[4] & M51;
		for (k = 3; k >= 0; k--) begin
			z[k] = z[k] + cy;
			cy = z[k] >> 51;
			z[k] = z[k] & M51;
		end
		z[4] = z[4] + cy * FOLD_MUL;
		if (canon && z[0] >= M51 && z[1] >= M51 && z[2] >= M51 && z[3] >= M51 &&
				z[4] >= P4) begin
			z[4] = z[4] - P4;
			for (k = 0; k < 4; k++)
				z[k] = '0;
			fold_hits++;
		end
		r.l0 = z[0][rdx51_pkg::LIMB_W-1:0];
		r.l1 = z[1][rdx51_pkg::LIMB_W-1:0];
		r.l2 = z[2][rdx51_pkg::LIMB_W-1:0];
		r.l3 = z[3][rdx51_pkg::LIMB_W-1:0];
		r.l4 = z[4][rdx51_pkg::TOP_W-1:0];
		return r;
	endfunction

	function automatic rdx51_pkg::word_t rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// mostly short gaps, a few long ones, and now and then a run with none
	function automatic int unsigned pick_gap(inout int unsigned quiet);
		int unsigned r;
		if (quiet != 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(99);
		if (r == 0)
			quiet = $urandom_range(60, 20);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 11);
	endfunction

	task automatic add_vector(input rdx51_pkg::word_t c[10], input bit canon, input bit typed,
			input limbs_t want);
		vector_t v;
		v.col = c;
		v.canon = canon;
		v.typed = typed;
		v.want = want;
		directed.push_back(v);
	endtask

	task automatic build_directed();
		limbs_t none;
		limbs_t zero;
		none = '{default: '0};
		zero = '{default: '0};
		// reset value of the register, no write yet
		add_vector('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b1, zero);
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, P4}, 1'b1, 1'b1, zero);
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, M51}, 1'b1, 1'b1,
			'{51'd0, 51'd0, 51'd0, 51'd0, 52'd18});
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, P4 - 1}, 1'b1, 1'b1,
			'{rdx51_pkg::MASK51, rdx51_pkg::MASK51, rdx51_pkg::MASK51, rdx51_pkg::MASK51,
			rdx51_pkg::P_LOW_LIMB - 52'd1});
		// top 13 bits of each high word fall off the shift
		add_vector('{HI13, 0, HI13, 0, HI13, 0, HI13, 0, HI13, 0}, 1'b1, 1'b1, zero);
		add_vector('{ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES},
			1'b1, 1'b0, none);
		add_vector('{ONES, ONES, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b0, none);
		add_vector('{ONES, 0, ONES, 0, ONES, 0, ONES, 0, ONES, 0}, 1'b1, 1'b0, none);
		add_vector('{0, ONES, 0, ONES, 0, ONES, 0, ONES, 0, ONES}, 1'b1, 1'b0, none);
		add_vector('{PAT_A, PAT_B, PAT_B, PAT_A, PAT_A, PAT_B, PAT_B, PAT_A, PAT_A, PAT_B},
			1'b1, 1'b0, none);
		// carry ripples through every limb and wraps
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, BIT51}, 1'b1, 1'b0, none);
		add_vector('{0, BIT51, 0, BIT51, 0, BIT51, 0, BIT51, 0, BIT51}, 1'b1, 1'b0, none);
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, P4}, 1'b0, 1'b1,
			'{rdx51_pkg::MASK51, rdx51_pkg::MASK51, rdx51_pkg::MASK51, rdx51_pkg::MASK51,
			rdx51_pkg::P_LOW_LIMB});
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, M51}, 1'b0, 1'b1,
			'{rdx51_pkg::MASK51, rdx51_pkg::MASK51, rdx51_pkg::MASK51, rdx51_pkg::MASK51,
			52'h7_ffff_ffff_ffff});
		add_vector('{ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES},
			1'b0, 1'b0, none);
		add_vector('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b1, zero);
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, BIT51}, 1'b0, 1'b0, none);
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, P4}, 1'b1, 1'b1, zero);
		add_vector('{0, M51, 0, M51, 0, M51, 0, M51, 0, M51}, 1'b1, 1'b1,
			'{51'd0, 51'd0, 51'd0, 51'd0, 52'd18});
		add_vector('{ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES},
			1'b1, 1'b0, none);
	endtask

	task automatic make_random(output rdx51_pkg::word_t c[10]);
		int unsigned kind;
		int unsigned k;
		kind = $urandom_range(99);
		for (k = 0; k < 5; k++) begin
			if (kind < 35) begin
				// shaped like real column sums: small high words
				c[2*k] = rand_word() >> $urandom_range(63, 14);
				c[2*k+1] = rand_word();
			end else if (kind < 60) begin
				c[2*k] = rand_word();
				c[2*k+1] = rand_word();
			end else if (kind < 82) begin
				c[2*k] = '0;
				c[2*k+1] = M51;
			end else begin
				case ($urandom_range(3))
					0: c[2*k] = '0;
					1: c[2*k] = ONES;
					2: c[2*k] = rand_word();
					default: c[2*k] = 64'd1 << $urandom_range(63);
				endcase
				case ($urandom_range(3))
					0: c[2*k+1] = '0;
					1: c[2*k+1] = ONES;
					2: c[2*k+1] = rand_word();
					default: c[2*k+1] = 64'd1 << $urandom_range(63);
				endcase
			end
		end
		// near the prime, sometimes pushed over so the carry wraps
		if (kind >= 60 && kind < 82) begin
			case ($urandom_range(3))
				0: c[9] = P4 + $urandom_range(30);
				1: c[9] = P4 - $urandom_range(3);
				2: c[9] = M51 + $urandom_range(40);
				default: c[2*$urandom_range(3)+1] = M51 - $urandom_range(2);
			endcase
		end
	endtask

	task automatic push_columns(input rdx51_pkg::word_t c[10], input limbs_t want);
		int unsigned gap;
		gap = pick_gap(send_quiet);
		if (gap != 0) begin
			col_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		col0_hi <= c[0];
		col0_lo <= c[1];
		col1_hi <= c[2];
		col1_lo <= c[3];
		col2_hi <= c[4];
		col2_lo <= c[5];
		col3_hi <= c[6];
		col3_lo <= c[7];
		col4_hi <= c[8];
		col4_lo <= c[9];
		col_valid <= 1'b1;
		@(posedge clk);
		while (col_stall)
			@(posedge clk);
		pending_limbs.push_back(want);
	endtask

	task automatic wait_drained();
		col_valid <= 1'b0;
		@(posedge clk);
		while (pending_limbs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_canon(input bit val);
		cfg_wen <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		canon_model = val;
		reg_writes++;
	endtask

	task automatic report_limbs(input string what, input limbs_t want);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s) at %0t", what, $time);
			$display("  expected %h %h %h %h %h", want.l0, want.l1, want.l2, want.l3,
				want.l4);
			$display("  actual   %h %h %h %h %h", limb_0, limb_1, limb_2, limb_3, limb_4);
		end
	endtask

	// stimulus
	initial begin
		rdx51_pkg::word_t cols[10];
		int unsigned      phase;
		int unsigned      n;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 1'b0;
		col_valid = 1'b0;
		{col0_hi, col0_lo, col1_hi, col1_lo, col2_hi} = '0;
		{col2_lo, col3_hi, col3_lo, col4_hi, col4_lo} = '0;
		canon_model = 1'b1;
		build_directed();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].canon != canon_model) begin
				wait_drained();
				write_canon(directed[i].canon);
			end
			push_columns(directed[i].col, directed[i].typed ? directed[i].want :
				reduce_mod_p(directed[i].col, canon_model));
			directed_sent++;
		end

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			write_canon(phase[0]);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(119) == 0)
					wait_drained();
				make_random(cols);
				push_columns(cols, reduce_mod_p(cols, canon_model));
				random_sent++;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d directed and %0d random transactions, %0d register writes",
			directed_sent, random_sent, reg_writes);
		$display("%0d results compared, %0d folded below the prime, %0d mismatches",
			results_seen, fold_hits, mismatches);
		if (mismatches == 0 && pending_limbs.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// output side back-pressure
	initial begin
		int unsigned n;
		limb_stall = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			n = pick_gap(recv_quiet);
			if (n != 0) begin
				limb_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			limb_stall <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_limbs
		limbs_t want;
		if (arst_n && limb_valid && !limb_stall) begin
			results_seen++;
			if (pending_limbs.size() == 0) begin
				want = '{default: '0};
				report_limbs("no result expected", want);
			end else begin
				want = pending_limbs.pop_front();
				if (limb_0 !== want.l0 || limb_1 !== want.l1 || limb_2 !== want.l2 ||
						limb_3 !== want.l3 || limb_4 !== want.l4)
					report_limbs("limb value", want);
			end
		end
	end

	// ends a hung run: no transaction on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((col_valid && !col_stall) || (limb_valid && !limb_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("FAILED: results differ");
					$finish;
				end
			end
		end
	end

endmodule

// ----- filelist.f -----
design/rdx51_pkg.sv
design/rdx51_carry.sv
design/radix51_mod_p25519_reduce.sv
tb/testbench.sv
